[src/sta_pkg.sv]
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants for the touch-screen ADC SPI block
// Holds divider widths, the divider request/status structs and the codes
// of the control byte and configuration register map.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int PIX_W      = 8;
  localparam int ADC_W      = 12;
  localparam int SREG_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Divider sizing: |dividend| <= 256 * 4095 < 2**20, |divisor| <= 255
  localparam int DVD_W = 20;
  localparam int DVS_W = 8;
  localparam int CNT_W = 5;

  // Control byte
  localparam int         START_BIT  = 7;
  localparam logic [2:0] CHAN_X     = 3'd5;
  localparam logic [2:0] CHAN_Y     = 3'd1;
  localparam logic [SREG_W-1:0] OTHER_LOAD = 16'h7FF8;
  localparam logic [ADC_W-1:0]  PEN_UP_Y   = 12'hFFF;

  // Item kinds
  localparam logic KIND_XFER     = 1'b0;
  localparam logic KIND_DESELECT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADC_X_FIRST    = 3'd0,
    CFG_ADC_X_SECOND   = 3'd1,
    CFG_ADC_Y_FIRST    = 3'd2,
    CFG_ADC_Y_SECOND   = 3'd3,
    CFG_SCREEN_X_FIRST = 3'd4,
    CFG_SCREEN_X_SECOND = 3'd5,
    CFG_SCREEN_Y_FIRST = 3'd6,
    CFG_SCREEN_Y_SECOND = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

[src/spi_touch_screen_adc.sv]
// ----------------------------------------------------------------------------
// spi_touch_screen_adc: SPI side of a touch-screen ADC controller
// Returns one byte per SPI transfer from a 16-bit shift register and loads
// calibrated X/Y or fixed readings on control bytes with the start bit set.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per SPI byte transfer or chip deselect. in_tuser is the
//            item kind (0 transfer, 1 deselect); in_tdata packs the control
//            byte, the pen state and the pen X/Y pixel position.
//   out_*  : one item per transfer item, carrying the register's high byte
//            before the shift. A deselect item clears the register and gives
//            no output item.
//   cfg_*  : calibration register writes (index, data), always ready. Write
//            only while the block is idle.
// Latency: the output item is valid the cycle after the input is accepted.
// Busy: an item that needs no calibration leaves the block idle. A
//   start byte selecting X or Y with the pen down runs the multiply state,
//   the setup state and the shared divider (one quotient bit per cycle
//   and a result state), and in_tready stays low until the divider is
//   done, so no new item is taken meanwhile.
// Stall: the output register holds until taken; in_tready stays low while
//   an untaken output item is waiting and out_tready is low.
// Reset: synchronous, active low; clears the shift register, the
//   calibration registers and all handshake state.
// ----------------------------------------------------------------------------
module spi_touch_screen_adc import sta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // spi_byte_in[7:0], pen_is_down[8],
                                            // pen_x_pixel[16:9], pen_y_pixel[24:17]
  input  logic                  in_tuser,   // kind[0]
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // spi_byte_out[7:0]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ABS  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  // ---------------------------------------------------------------- fields
  logic [7:0]       spi_byte_in;
  logic             pen_is_down;
  logic [PIX_W-1:0] pen_x_pixel;
  logic [PIX_W-1:0] pen_y_pixel;
  logic [2:0]       chan;

  assign spi_byte_in = in_tdata[7:0];
  assign pen_is_down = in_tdata[8];
  assign pen_x_pixel = in_tdata[16:9];
  assign pen_y_pixel = in_tdata[24:17];
  assign chan        = spi_byte_in[6:4];

  // ---------------------------------------------------------------- config
  logic [ADC_W-1:0] adc_x_first_r, adc_x_second_r, adc_y_first_r, adc_y_second_r;
  logic [PIX_W-1:0] scr_x_first_r, scr_x_second_r, scr_y_first_r, scr_y_second_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_x_first_r  <= '0;
      adc_x_second_r <= '0;
      adc_y_first_r  <= '0;
      adc_y_second_r <= '0;
      scr_x_first_r  <= '0;
      scr_x_second_r <= '0;
      scr_y_first_r  <= '0;
      scr_y_second_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ADC_X_FIRST:     adc_x_first_r  <= cfg_data;
        CFG_ADC_X_SECOND:    adc_x_second_r <= cfg_data;
        CFG_ADC_Y_FIRST:     adc_y_first_r  <= cfg_data;
        CFG_ADC_Y_SECOND:    adc_y_second_r <= cfg_data;
        CFG_SCREEN_X_FIRST:  scr_x_first_r  <= cfg_data[PIX_W-1:0];
        CFG_SCREEN_X_SECOND: scr_x_second_r <= cfg_data[PIX_W-1:0];
        CFG_SCREEN_Y_FIRST:  scr_y_first_r  <= cfg_data[PIX_W-1:0];
        CFG_SCREEN_Y_SECOND: scr_y_second_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  state_t               state_r, state_nxt;
  logic [SREG_W-1:0]    sreg_r, sreg_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [7:0]           out_tdata_r, out_tdata_nxt;
  logic                 axis_y_r, axis_y_nxt;   // 1: Y axis selected
  logic [PIX_W-1:0]     pix_r, pix_nxt;
  logic signed [20:0]   prod_r, prod_nxt;       // (p - s1 + 1) * (a2 - a1)
  logic signed [8:0]    sd_r, sd_nxt;           // screen delta, zero forced to 1
  logic                 neg_r, neg_nxt;

  logic in_acc;
  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Axis-selected calibration points
  logic [PIX_W-1:0] s1, s2;
  logic [ADC_W-1:0] a1, a2;
  assign s1 = axis_y_r ? scr_y_first_r  : scr_x_first_r;
  assign s2 = axis_y_r ? scr_y_second_r : scr_x_second_r;
  assign a1 = axis_y_r ? adc_y_first_r  : adc_x_first_r;
  assign a2 = axis_y_r ? adc_y_second_r : adc_x_second_r;

  // Multiply stage
  logic signed [9:0]  dp;
  logic signed [12:0] da;
  logic signed [22:0] prod_full;
  logic signed [8:0]  sd_raw;
  assign dp        = $signed({2'b00, pix_r}) - $signed({2'b00, s1}) + 10'sd1;
  assign da        = $signed({1'b0, a2}) - $signed({1'b0, a1});
  assign prod_full = dp * da;
  assign sd_raw    = $signed({1'b0, s2}) - $signed({1'b0, s1});

  // Divider operands: magnitudes, sign applied after the divide
  logic [20:0] prod_mag;
  logic [8:0]  sd_mag;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [DVD_W-1:0] quot;

  assign prod_mag         = prod_r[20] ? (21'd0 - prod_r) : prod_r;
  assign sd_mag           = sd_r[8] ? (9'd0 - sd_r) : sd_r;
  assign div_req.start    = (state_r == S_ABS);
  assign div_req.dividend = prod_mag[DVD_W-1:0];
  assign div_req.divisor  = sd_mag[DVS_W-1:0];

  sta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp),
    .quot  (quot)
  );

  // Only the low 13 bits of the calibrated value survive the shift by 3
  logic [12:0] cal_val;
  assign cal_val = neg_r ? ({1'b0, a1} - quot[12:0]) : ({1'b0, a1} + quot[12:0]);

  always_comb begin
    state_nxt      = state_r;
    sreg_nxt       = sreg_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    axis_y_nxt     = axis_y_r;
    pix_nxt        = pix_r;
    prod_nxt       = prod_r;
    sd_nxt         = sd_r;
    neg_nxt        = neg_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == KIND_DESELECT) begin
            sreg_nxt = '0;
          end else begin
            // emit the high byte, then shift
            out_tvalid_nxt = 1'b1;
            out_tdata_nxt  = sreg_r[15:8];
            sreg_nxt       = {sreg_r[7:0], 8'h00};
            if (spi_byte_in[START_BIT]) begin
              priority if (chan == CHAN_X || chan == CHAN_Y) begin
                if (pen_is_down) begin
                  axis_y_nxt = (chan == CHAN_Y);
                  pix_nxt    = (chan == CHAN_Y) ? pen_y_pixel : pen_x_pixel;
                  state_nxt  = S_MUL;
                end else if (chan == CHAN_Y) begin
                  sreg_nxt = {1'b0, PEN_UP_Y, 3'b000};
                end else begin
                  sreg_nxt = '0;
                end
              end else begin
                sreg_nxt = OTHER_LOAD;
              end
            end
          end
        end
      end
      S_MUL: begin
        prod_nxt  = prod_full[20:0];
        sd_nxt    = (sd_raw == 9'sd0) ? 9'sd1 : sd_raw;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt   = prod_r[20] ^ sd_r[8];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          sreg_nxt  = {cal_val, 3'b000};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sreg_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sreg_r       <= sreg_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    axis_y_r    <= axis_y_nxt;
    pix_r       <= pix_nxt;
    prod_r      <= prod_nxt;
    sd_r        <= sd_nxt;
    neg_r       <= neg_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------- checks
  a_deselect_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_DESELECT) |=> (sreg_r == '0))
    else $error("deselect item did not clear the shift register");

  a_byte_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_XFER) |=>
      (out_tvalid_r && out_tdata_r == $past(sreg_r[15:8])))
    else $error("output byte is not the prior high byte");

  a_deselect_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == KIND_DESELECT && !out_tvalid_r) |=> !out_tvalid_r)
    else $error("deselect item produced an output item");

  a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_div_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> !in_tready)
    else $error("input accepted while divider busy");

endmodule

[src/sta_div.sv]
// ----------------------------------------------------------------------------
// sta_div: iterative unsigned restoring divider
// One quotient bit per cycle; the quotient holds while done is high.
// ----------------------------------------------------------------------------
module sta_div import sta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output div_rsp_t         rsp,
  output logic [DVD_W-1:0] quot
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } dstate_t;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  dstate_t          state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    quo_nxt   = quo_r;
    unique case (state_r)
      D_IDLE: begin
        if (req.start) begin
          quo_nxt   = req.dividend;
          dvs_nxt   = req.divisor;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        // restore or keep the trial remainder, shift in one quotient bit
        rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], ge};
        if (cnt_r == LAST) begin
          state_nxt = D_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      D_DONE: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = (state_r != D_IDLE);
  assign rsp.done = (state_r == D_DONE);
  assign quot     = quo_r;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the touch-screen ADC SPI block
// Streams SPI byte transfers and chip deselects into the block, predicts each
// returned byte from a local shift register and calibration copy, and checks
// the results in order under random back-pressure and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import sta_pkg::*;

  localparam int RESET_CYCLES = 6;
  // settle wait, long enough for a calibrating load to finish after its accept
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_AT       = 400;   // accepted items before the long stall
  localparam int HOLD_LEN      = 500;   // length of the long stall in cycles
  localparam int RANDOM_BLOCK  = 330;   // random items per calibration setting

  // one transfer or deselect as the host presents it
  typedef struct packed {
    logic       kind;
    logic [7:0] ctrl;
    logic       pen;
    logic [7:0] px;
    logic [7:0] py;
  } spi_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;   // spi_byte_in[7:0], pen_is_down[8],
                                          // pen_x_pixel[16:9], pen_y_pixel[24:17]
  logic                  in_tuser = 1'b0; // kind[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // spi_byte_out[7:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spi_touch_screen_adc u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local view of the block: calibration registers and the MISO shift register
  logic [11:0] cal_regs [8];
  logic [15:0] miso_shift = '0;

  spi_item_t   host_q [$];      // items waiting for the driver
  logic [7:0]  miso_bytes_q [$]; // predicted bytes, oldest first
  spi_item_t   bus_item = '0;   // item currently offered on in_*
  int          items_accepted = 0;
  int          errors = 0;
  int          tx_idle_pct = 14;
  int          rx_idle_pct = 87;
  int          hold_left = 0;
  logic        hold_fired = 1'b0;
  int          cycle_count = 0;

  initial begin
    for (int i = 0; i < 8; i++) cal_regs[i] = '0;
  end

  // Screen coordinate to ADC value: signed divide truncating toward zero, a
  // zero screen span counts as one, result kept to 16 bits.
  function automatic logic [15:0] map_to_adc(input int p, input int s1, input int s2,
                                             input int a1, input int a2);
    int span;
    int prod;
    int val;
    span = s2 - s1;
    if (span == 0) span = 1;
    prod = (p - s1 + 1) * (a2 - a1);
    val  = prod / span + a1;
    return val[15:0];
  endfunction

  // Return the byte shifted out by one transfer and advance the shift register.
  function automatic logic [7:0] shift_out_byte(input spi_item_t it);
    logic [7:0]  miso_byte;
    logic [15:0] adc_x;
    logic [15:0] adc_y;
    miso_byte  = miso_shift[15:8];
    miso_shift = {miso_shift[7:0], 8'h00};
    adc_x = '0;
    adc_y = {4'h0, PEN_UP_Y};
    if (it.pen) begin
      adc_x = map_to_adc(int'(it.px),
                         int'(cal_regs[CFG_SCREEN_X_FIRST]),
                         int'(cal_regs[CFG_SCREEN_X_SECOND]),
                         int'(cal_regs[CFG_ADC_X_FIRST]),
                         int'(cal_regs[CFG_ADC_X_SECOND]));
      adc_y = map_to_adc(int'(it.py),
                         int'(cal_regs[CFG_SCREEN_Y_FIRST]),
                         int'(cal_regs[CFG_SCREEN_Y_SECOND]),
                         int'(cal_regs[CFG_ADC_Y_FIRST]),
                         int'(cal_regs[CFG_ADC_Y_SECOND]));
    end
    if (it.ctrl[START_BIT]) begin
      case (it.ctrl[START_BIT-1 -: 3])
        CHAN_X:  miso_shift = {adc_x[12:0], 3'b000};
        CHAN_Y:  miso_shift = {adc_y[12:0], 3'b000};
        default: miso_shift = OTHER_LOAD;
      endcase
    end
    return miso_byte;
  endfunction

  // Driver: predict on accept, then offer the next pending item unless the
  // sender idles this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        items_accepted <= items_accepted + 1;
        if (bus_item.kind == KIND_DESELECT) begin
          miso_shift = '0;
        end else begin
          miso_bytes_q.push_back(shift_out_byte(bus_item));
        end
      end
      // the bus is free once the current item is gone or nothing is offered
      if (!in_tvalid || in_tready) begin
        if (host_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          bus_item = host_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= bus_item.kind;
          in_tdata  <= {7'h00, bus_item.py, bus_item.px, bus_item.pen, bus_item.ctrl};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, counted here so the driver keeps pushing meanwhile
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && items_accepted >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare every returned byte with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (miso_bytes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual 0x%02h", $time, out_tdata);
        end else begin
          logic [7:0] want;
          want = miso_bytes_q.pop_front();
          if (want !== out_tdata) begin
            errors++;
            $display("%0t: byte mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want, out_tdata);
          end
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] ctrl_byte(input logic start, input logic [2:0] chan,
                                           input logic [3:0] low);
    return {start, chan, low};
  endfunction

  // Value biased toward the ends of its range
  function automatic logic [11:0] pick_edge(input logic [11:0] top);
    case ($urandom_range(3))
      0:       return '0;
      1:       return top;
      default: return 12'($urandom_range(top));
    endcase
  endfunction

  task automatic queue_item(input logic kind, input logic [7:0] ctrl, input logic pen,
                            input logic [7:0] px, input logic [7:0] py);
    spi_item_t it;
    it.kind = kind;
    it.ctrl = ctrl;
    it.pen  = pen;
    it.px   = px;
    it.py   = py;
    host_q.push_back(it);
  endtask

  // Hold until nothing is pending or expected, then let the divider finish.
  task automatic wait_idle();
    do @(posedge clk);
    while (host_q.size() != 0 || in_tvalid || miso_bytes_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cal(input cfg_idx_t idx, input logic [11:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    // screen registers keep only their pixel bits
    cal_regs[idx] = (idx >= CFG_SCREEN_X_FIRST) ? (value & 12'h0FF) : value;
  endtask

  task automatic program_cal(input logic [11:0] ax1, input logic [11:0] ax2,
                             input logic [11:0] ay1, input logic [11:0] ay2,
                             input logic [7:0] sx1, input logic [7:0] sx2,
                             input logic [7:0] sy1, input logic [7:0] sy2);
    write_cal(CFG_ADC_X_FIRST, ax1);
    write_cal(CFG_ADC_X_SECOND, ax2);
    write_cal(CFG_ADC_Y_FIRST, ay1);
    write_cal(CFG_ADC_Y_SECOND, ay2);
    write_cal(CFG_SCREEN_X_FIRST, {4'h0, sx1});
    write_cal(CFG_SCREEN_X_SECOND, {4'h0, sx2});
    write_cal(CFG_SCREEN_Y_FIRST, {4'h0, sy1});
    write_cal(CFG_SCREEN_Y_SECOND, {4'h0, sy2});
  endtask

  task automatic program_random_cal(input bit same_screen);
    logic [7:0] sx1;
    logic [7:0] sy1;
    sx1 = 8'(pick_edge(12'd255));
    sy1 = 8'(pick_edge(12'd255));
    program_cal(pick_edge(12'd4095), pick_edge(12'd4095),
                pick_edge(12'd4095), pick_edge(12'd4095),
                sx1, same_screen ? sx1 : 8'(pick_edge(12'd255)),
                sy1, same_screen ? sy1 : 8'(pick_edge(12'd255)));
  endtask

  // Mostly host-like reads (control byte plus two clocking bytes, now and
  // then a deselect), the rest raw noise including stray deselects.
  task automatic add_random_items(input int count);
    int         added;
    logic [2:0] chan;
    logic       pen;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] rd;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(9))
          0, 1, 2, 3: chan = CHAN_X;
          4, 5, 6, 7: chan = CHAN_Y;
          default:    chan = 3'($urandom_range(7));
        endcase
        pen = ($urandom_range(9) < 7);
        px  = 8'(pick_edge(12'd255));
        py  = 8'(pick_edge(12'd255));
        queue_item(KIND_XFER, ctrl_byte(1'b1, chan, 4'($urandom)), pen, px, py);
        rd = ($urandom_range(3) == 0) ? {1'b0, 7'($urandom)} : 8'h00;
        queue_item(KIND_XFER, rd, pen, 8'($urandom), 8'($urandom));
        // overlap the next command with the last read byte now and then
        if ($urandom_range(4) == 0) begin
          rd = ctrl_byte(1'b1, 3'($urandom_range(7)), 4'($urandom));
        end else begin
          rd = ($urandom_range(3) == 0) ? {1'b0, 7'($urandom)} : 8'h00;
        end
        queue_item(KIND_XFER, rd, pen, 8'($urandom), 8'($urandom));
        added += 3;
        if ($urandom_range(9) == 0) begin
          queue_item(KIND_DESELECT, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
          added++;
        end
      end else begin
        queue_item(($urandom_range(7) == 0) ? KIND_DESELECT : KIND_XFER, 8'($urandom),
                   1'($urandom), 8'($urandom), 8'($urandom));
        added++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: both spans are zero and both ADC deltas are zero.
    queue_item(KIND_XFER, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(KIND_XFER, ctrl_byte(1'b1, CHAN_X, 4'h0), 1'b1, 8'h00, 8'h00);
    queue_item(KIND_XFER, ctrl_byte(1'b1, CHAN_Y, 4'h0), 1'b0, 8'h00, 8'h00);
    queue_item(KIND_XFER, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(KIND_XFER, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(KIND_DESELECT, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    wait_idle();

    // Equal screen points with full-scale ADC deltas: results overflow 16 bits.
    program_cal(12'd0, 12'd4095, 12'd4095, 12'd0, 8'd128, 8'd128, 8'd0, 8'd0);
    for (int ch = 0; ch < 8; ch++) begin
      queue_item(KIND_XFER, ctrl_byte(1'b1, 3'(ch), 4'h0), 1'b1, 8'hFF, 8'hFF);
    end
    // start bit clear with every other bit set: shift only
    queue_item(KIND_XFER, ctrl_byte(1'b0, 3'h7, 4'hF), 1'b1, 8'h00, 8'h00);
    queue_item(KIND_XFER, ctrl_byte(1'b1, CHAN_X, 4'hF), 1'b1, 8'h00, 8'h00);
    queue_item(KIND_XFER, ctrl_byte(1'b1, CHAN_Y, 4'h0), 1'b1, 8'h00, 8'h00);
    // deselect right after a load must wipe it
    queue_item(KIND_DESELECT, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    queue_item(KIND_XFER, 8'h00, 1'b0, 8'h00, 8'h00);
    // pen up: X reads zero, Y reads full scale
    queue_item(KIND_XFER, ctrl_byte(1'b1, CHAN_X, 4'h0), 1'b0, 8'hFF, 8'hFF);
    queue_item(KIND_XFER, ctrl_byte(1'b1, CHAN_Y, 4'h0), 1'b0, 8'hFF, 8'hFF);
    queue_item(KIND_XFER, 8'h00, 1'b0, 8'h00, 8'h00);
    queue_item(KIND_XFER, 8'h00, 1'b0, 8'h00, 8'h00);
    wait_idle();

    // Random traffic, sender lightly idle and receiver mostly stalled
    program_cal(12'd100, 12'd3900, 12'd200, 12'd3800, 8'd10, 8'd240, 8'd20, 8'd250);
    add_random_items(RANDOM_BLOCK);
    wait_idle();
    program_cal(12'd4095, 12'd0, 12'd0, 12'd4095, 8'd255, 8'd0, 8'd0, 8'd255);
    add_random_items(RANDOM_BLOCK);
    wait_idle();

    // Swap the idling sides
    tx_idle_pct <= 87;
    rx_idle_pct <= 14;
    program_random_cal(1'b0);
    add_random_items(RANDOM_BLOCK);
    wait_idle();
    program_random_cal(1'b1);
    add_random_items(RANDOM_BLOCK);
    wait_idle();

    // Full rate on both sides
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    program_random_cal(1'b0);
    add_random_items(RANDOM_BLOCK);
    wait_idle();

    foreach (miso_bytes_q[i]) begin
      errors++;
      $display("%0t: missing byte: expected 0x%02h, actual none", $time, miso_bytes_q[i]);
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
